// File: rtl/ntre_pkg.sv
// Shared types and constants for the NDEF text record extractor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ntre_pkg;

   // One input beat: a byte of the tag data area and its end marker
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_content;
   } req_payload_type;

   // One result beat
   typedef struct packed {
      logic [7:0] text_byte;
      logic       has_byte;
      logic [2:0] outcome;
      logic       last;
   } rsp_payload_type;

   // Outcome codes
   localparam logic [2:0] OUTCOME_CONTINUE  = 3'd0;
   localparam logic [2:0] OUTCOME_COMPLETE  = 3'd1;
   localparam logic [2:0] OUTCOME_TERM_TLV  = 3'd2;
   localparam logic [2:0] OUTCOME_NO_TEXT   = 3'd3;
   localparam logic [2:0] OUTCOME_TRUNCATED = 3'd4;

   // TLV type and length codes
   localparam logic [7:0] TLV_NULL     = 8'h00;
   localparam logic [7:0] TLV_NDEF     = 8'h03;
   localparam logic [7:0] TLV_TERM     = 8'hFE;
   localparam logic [7:0] TLV_LEN_LONG = 8'hFF;

   // NDEF record header flags
   localparam int unsigned FLAG_ME_BIT = 6;
   localparam int unsigned FLAG_SR_BIT = 4;
   localparam int unsigned FLAG_IL_BIT = 3;
   localparam logic [2:0]  TNF_WELL_KNOWN = 3'h1;

   // Register file
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        CSR_IDX_WANTED_TYPE = 1'b0;
   localparam logic [7:0]  WANTED_TYPE_RESET   = 8'd84;

endpackage : ntre_pkg

`default_nettype wire

// File: rtl/ndef_text_record_extractor_unit.sv
// NDEF text record extractor: walks the TLV blocks of a tag data area and
// emits the text of the first matching well-known record.
// Usage:
//   req_* : one tag data byte per beat, end_of_content set on the last byte.
//   rsp_* : at most one result per byte: a text character, or a status beat
//           with has_byte low; last marks the end of this tag's search.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready : register at address 0
//           holds the wanted one-byte record type (reset 'T'); write it idle.
// Flow: an accepted byte lands in the input register; the parser handles it
//   from there and writes the result queue, which presents the result.
// Throughput: one byte per cycle while the result queue is not full.
// Stalls: a two-entry result queue keeps bytes flowing while a result waits;
//   req_ready drops while the queue is full and a byte waits in the input
//   register, whatever rsp_ready does in that cycle.
// Reset: synchronous, active high; clears the parse state, empties the queue
//   and loads the reset record type. end_of_content also rearms the parser.
// Depends on ntre_pkg, ntre_csr, ntre_parser and ntre_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module ndef_text_record_extractor_unit import ntre_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic            [7:0] wanted_type;
   logic                  out_ready;
   logic                  out_push;
   rsp_payload_type       out_data;

   ntre_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .wanted_type (wanted_type)
   );

   ntre_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .wanted_type (wanted_type),
      .out_ready   (out_ready),
      .out_push    (out_push),
      .out_data    (out_data)
   );

   ntre_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (out_push),
      .push_data   (out_data),
      .can_push    (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule : ndef_text_record_extractor_unit

`default_nettype wire

// File: rtl/ntre_csr.sv
// Register file of the NDEF text record extractor: the wanted record type.
// APB-style write and read; depends on ntre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntre_csr import ntre_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [7:0]            wanted_type
);

   logic [7:0] wanted_ff;
   logic [7:0] wanted_in;
   logic       reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      wanted_in = wanted_ff;
      if (wr_en && (reg_idx == CSR_IDX_WANTED_TYPE)) begin
         wanted_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= WANTED_TYPE_RESET;
      end else begin
         wanted_ff <= wanted_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         CSR_IDX_WANTED_TYPE: prdata = {{(CSR_DATA_W-8){1'b0}}, wanted_ff};
         default:             prdata = '0;
      endcase
   end

   assign wanted_type = wanted_ff;

endmodule : ntre_csr

`default_nettype wire

// File: rtl/ntre_parser.sv
// TLV walker and NDEF record parser: input register, parse state and the
// single-pass next-state logic. Depends on ntre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntre_parser import ntre_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic [7:0]      wanted_type,
   input  wire logic            out_ready,
   output logic                 out_push,
   output rsp_payload_type      out_data
);

   typedef enum logic [15:0] {
      PH_TLV_TYPE   = 16'h0001,
      PH_TLV_LEN    = 16'h0002,
      PH_TLV_LEN_HI = 16'h0004,
      PH_TLV_LEN_LO = 16'h0008,
      PH_TLV_SKIP   = 16'h0010,
      PH_REC_FLAGS  = 16'h0020,
      PH_REC_TLEN   = 16'h0040,
      PH_REC_PLEN   = 16'h0080,
      PH_REC_IDLEN  = 16'h0100,
      PH_REC_TYPE   = 16'h0200,
      PH_REC_SKIP   = 16'h0400,
      PH_TXT_ID     = 16'h0800,
      PH_TXT_STATUS = 16'h1000,
      PH_TXT_LANG   = 16'h2000,
      PH_TXT_BODY   = 16'h4000,
      PH_DONE       = 16'h8000
   } phase_type;

   // input register
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            advance;

   // parse state
   phase_type   phase_ff,    phase_in;
   logic [15:0] tlv_left_ff, tlv_left_in;
   logic [7:0]  flags_ff,    flags_in;
   logic [7:0]  tlen_ff,     tlen_in;
   logic [7:0]  idlen_ff,    idlen_in;
   logic [31:0] pl_left_ff,  pl_left_in;
   logic [1:0]  len_idx_ff,  len_idx_in;
   logic [5:0]  lang_left_ff, lang_left_in;
   logic [32:0] skip_left_ff, skip_left_in;
   logic        is_ndef_ff,  is_ndef_in;

   // helpers
   logic [7:0]  b;
   logic        eoc;
   logic        in_record;
   logic [15:0] tlv_dec;
   phase_type   rec_end_phase;
   logic [31:0] pl_plen;
   logic [31:0] pl_dec;
   logic [32:0] skip_dec;
   logic [7:0]  hd_tlen;
   logic [7:0]  hd_idlen;
   logic [31:0] hd_pl;
   logic [32:0] skip_sum;
   logic        hdr_match;
   logic [15:0] long_len;
   logic [5:0]  lang_raw;
   logic [5:0]  lang_cut;
   logic [31:0] pl_after_lang;

   logic            res_valid;
   rsp_payload_type res;

   assign advance   = in_valid_ff && out_ready;
   assign req_ready = !in_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   assign b   = in_data_ff.data_byte;
   assign eoc = in_data_ff.end_of_content;

   // shared arithmetic for this beat
   always_comb begin
      in_record = (phase_ff == PH_REC_FLAGS) || (phase_ff == PH_REC_TLEN) ||
                  (phase_ff == PH_REC_PLEN)  || (phase_ff == PH_REC_IDLEN) ||
                  (phase_ff == PH_REC_TYPE)  || (phase_ff == PH_REC_SKIP) ||
                  (phase_ff == PH_TXT_ID)    || (phase_ff == PH_TXT_STATUS) ||
                  (phase_ff == PH_TXT_LANG)  || (phase_ff == PH_TXT_BODY);
      tlv_dec  = (in_record && (tlv_left_ff != 16'd0)) ? (tlv_left_ff - 16'd1)
                                                        : tlv_left_ff;
      if (tlv_dec == 16'd0) begin
         rec_end_phase = PH_TLV_TYPE;
      end else if (flags_ff[FLAG_ME_BIT]) begin
         rec_end_phase = PH_TLV_SKIP;
      end else begin
         rec_end_phase = PH_REC_FLAGS;
      end

      pl_plen  = flags_ff[FLAG_SR_BIT] ? {24'd0, b} : {pl_left_ff[23:0], b};
      pl_dec   = (pl_left_ff != 32'd0) ? (pl_left_ff - 32'd1) : pl_left_ff;
      skip_dec = (skip_left_ff != 33'd0) ? (skip_left_ff - 33'd1) : skip_left_ff;

      // bytes still to skip for a record that is not taken
      hd_tlen  = (phase_ff == PH_REC_TYPE) ? 8'd0 : tlen_ff;
      hd_idlen = (phase_ff == PH_REC_IDLEN) ? b : idlen_ff;
      hd_pl    = (phase_ff == PH_REC_PLEN) ? pl_plen : pl_left_ff;
      skip_sum = {25'd0, hd_tlen} + {25'd0, hd_idlen} + {1'b0, hd_pl};
      hdr_match = (flags_ff[2:0] == TNF_WELL_KNOWN) && (tlen_ff == 8'd1);

      long_len = {tlv_left_ff[15:8], b};

      // language code is cut to what is left of the payload
      lang_raw = b[5:0];
      if ({26'd0, lang_raw} > pl_dec) begin
         lang_cut = pl_dec[5:0];
      end else begin
         lang_cut = lang_raw;
      end
      pl_after_lang = pl_dec - {26'd0, lang_cut};
   end

   always_comb begin
      phase_in     = phase_ff;
      tlv_left_in  = tlv_dec;
      flags_in     = flags_ff;
      tlen_in      = tlen_ff;
      idlen_in     = idlen_ff;
      pl_left_in   = pl_left_ff;
      len_idx_in   = len_idx_ff;
      lang_left_in = lang_left_ff;
      skip_left_in = skip_left_ff;
      is_ndef_in   = is_ndef_ff;
      res_valid    = 1'b0;
      res          = '0;

      if (phase_ff != PH_DONE) begin
         unique case (phase_ff)
            PH_TLV_TYPE: begin
               if (b == TLV_TERM) begin
                  res_valid   = 1'b1;
                  res.outcome = OUTCOME_TERM_TLV;
                  res.last    = 1'b1;
                  phase_in    = PH_DONE;
               end else if (b != TLV_NULL) begin
                  is_ndef_in = (b == TLV_NDEF);
                  phase_in   = PH_TLV_LEN;
               end
            end
            PH_TLV_LEN: begin
               if (b == TLV_LEN_LONG) begin
                  phase_in = PH_TLV_LEN_HI;
               end else begin
                  tlv_left_in = {8'd0, b};
                  if (b == 8'd0) begin
                     phase_in = PH_TLV_TYPE;
                  end else begin
                     phase_in = is_ndef_ff ? PH_REC_FLAGS : PH_TLV_SKIP;
                  end
               end
            end
            PH_TLV_LEN_HI: begin
               tlv_left_in = {b, 8'd0};
               phase_in    = PH_TLV_LEN_LO;
            end
            PH_TLV_LEN_LO: begin
               tlv_left_in = long_len;
               if (long_len == 16'd0) begin
                  phase_in = PH_TLV_TYPE;
               end else begin
                  phase_in = is_ndef_ff ? PH_REC_FLAGS : PH_TLV_SKIP;
               end
            end
            PH_TLV_SKIP: begin
               tlv_left_in = (tlv_left_ff != 16'd0) ? (tlv_left_ff - 16'd1) : tlv_left_ff;
               if (tlv_left_in == 16'd0) begin
                  phase_in = PH_TLV_TYPE;
               end
            end
            PH_REC_FLAGS: begin
               flags_in   = b;
               tlen_in    = 8'd0;
               idlen_in   = 8'd0;
               pl_left_in = 32'd0;
               len_idx_in = 2'd0;
               phase_in   = PH_REC_TLEN;
            end
            PH_REC_TLEN: begin
               tlen_in  = b;
               phase_in = PH_REC_PLEN;
            end
            PH_REC_PLEN: begin
               pl_left_in = pl_plen;
               if (!flags_ff[FLAG_SR_BIT]) begin
                  len_idx_in = len_idx_ff + 2'd1;
               end
               if (flags_ff[FLAG_SR_BIT] || (len_idx_ff == 2'd3)) begin
                  if (flags_ff[FLAG_IL_BIT]) begin
                     phase_in = PH_REC_IDLEN;
                  end else if (hdr_match) begin
                     phase_in = PH_REC_TYPE;
                  end else begin
                     skip_left_in = skip_sum;
                     phase_in     = (skip_sum == 33'd0) ? rec_end_phase : PH_REC_SKIP;
                  end
               end
            end
            PH_REC_IDLEN: begin
               idlen_in = b;
               if (hdr_match) begin
                  phase_in = PH_REC_TYPE;
               end else begin
                  skip_left_in = skip_sum;
                  phase_in     = (skip_sum == 33'd0) ? rec_end_phase : PH_REC_SKIP;
               end
            end
            PH_REC_TYPE: begin
               if (b == wanted_type) begin
                  skip_left_in = {25'd0, idlen_ff};
                  if (idlen_ff != 8'd0) begin
                     phase_in = PH_TXT_ID;
                  end else if (pl_left_ff != 32'd0) begin
                     phase_in = PH_TXT_STATUS;
                  end else begin
                     res_valid   = 1'b1;
                     res.outcome = OUTCOME_COMPLETE;
                     res.last    = 1'b1;
                     phase_in    = PH_DONE;
                  end
               end else begin
                  skip_left_in = skip_sum;
                  phase_in     = (skip_sum == 33'd0) ? rec_end_phase : PH_REC_SKIP;
               end
            end
            PH_REC_SKIP: begin
               skip_left_in = skip_dec;
               if (skip_dec == 33'd0) begin
                  phase_in = rec_end_phase;
               end
            end
            PH_TXT_ID: begin
               skip_left_in = skip_dec;
               if (skip_dec == 33'd0) begin
                  if (pl_left_ff != 32'd0) begin
                     phase_in = PH_TXT_STATUS;
                  end else begin
                     res_valid   = 1'b1;
                     res.outcome = OUTCOME_COMPLETE;
                     res.last    = 1'b1;
                     phase_in    = PH_DONE;
                  end
               end
            end
            PH_TXT_STATUS: begin
               lang_left_in = lang_cut;
               pl_left_in   = pl_after_lang;
               if (lang_cut != 6'd0) begin
                  phase_in = PH_TXT_LANG;
               end else if (pl_after_lang != 32'd0) begin
                  phase_in = PH_TXT_BODY;
               end else begin
                  res_valid   = 1'b1;
                  res.outcome = OUTCOME_COMPLETE;
                  res.last    = 1'b1;
                  phase_in    = PH_DONE;
               end
            end
            PH_TXT_LANG: begin
               lang_left_in = (lang_left_ff != 6'd0) ? (lang_left_ff - 6'd1) : lang_left_ff;
               if (lang_left_in == 6'd0) begin
                  if (pl_left_ff != 32'd0) begin
                     phase_in = PH_TXT_BODY;
                  end else begin
                     res_valid   = 1'b1;
                     res.outcome = OUTCOME_COMPLETE;
                     res.last    = 1'b1;
                     phase_in    = PH_DONE;
                  end
               end
            end
            PH_TXT_BODY: begin
               pl_left_in    = pl_dec;
               res_valid     = 1'b1;
               res.text_byte = b;
               res.has_byte  = 1'b1;
               if (pl_dec == 32'd0) begin
                  res.outcome = OUTCOME_COMPLETE;
                  res.last    = 1'b1;
                  phase_in    = PH_DONE;
               end else begin
                  res.outcome = OUTCOME_CONTINUE;
                  res.last    = 1'b0;
               end
            end
            default: begin
            end
         endcase

         // last byte of the tag closes any open search
         if (eoc) begin
            if (res_valid) begin
               if (!res.last) begin
                  res.outcome = OUTCOME_TRUNCATED;
                  res.last    = 1'b1;
               end
            end else begin
               res_valid = 1'b1;
               res.last  = 1'b1;
               if ((phase_in == PH_TXT_ID) || (phase_in == PH_TXT_STATUS) ||
                   (phase_in == PH_TXT_LANG) || (phase_in == PH_TXT_BODY)) begin
                  res.outcome = OUTCOME_TRUNCATED;
               end else begin
                  res.outcome = OUTCOME_NO_TEXT;
               end
            end
         end
      end

      // rearm for the next tag
      if (eoc) begin
         phase_in     = PH_TLV_TYPE;
         tlv_left_in  = 16'd0;
         flags_in     = 8'd0;
         tlen_in      = 8'd0;
         idlen_in     = 8'd0;
         pl_left_in   = 32'd0;
         len_idx_in   = 2'd0;
         lang_left_in = 6'd0;
         skip_left_in = 33'd0;
         is_ndef_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TLV_TYPE;
         tlv_left_ff  <= 16'd0;
         flags_ff     <= 8'd0;
         tlen_ff      <= 8'd0;
         idlen_ff     <= 8'd0;
         pl_left_ff   <= 32'd0;
         len_idx_ff   <= 2'd0;
         lang_left_ff <= 6'd0;
         skip_left_ff <= 33'd0;
         is_ndef_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         tlv_left_ff  <= tlv_left_in;
         flags_ff     <= flags_in;
         tlen_ff      <= tlen_in;
         idlen_ff     <= idlen_in;
         pl_left_ff   <= pl_left_in;
         len_idx_ff   <= len_idx_in;
         lang_left_ff <= lang_left_in;
         skip_left_ff <= skip_left_in;
         is_ndef_ff   <= is_ndef_in;
      end
   end

   assign out_push = advance && res_valid;
   assign out_data = res;

endmodule : ntre_parser

`default_nettype wire

// File: rtl/ntre_out_buf.sv
// Two-entry result queue between the parser and the result channel.
// Keeps the parser running while a result waits; depends on ntre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntre_out_buf import ntre_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire rsp_payload_type push_data,
   output logic                 can_push,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   rsp_payload_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       pop;

   assign can_push    = (count_ff != 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : ntre_out_buf

`default_nettype wire

// File: tb/tb_ndef_text_record_extractor_unit.sv
// Testbench for ndef_text_record_extractor_unit: directed and random tag images,
// checked beat by beat against an in-bench model of the TLV/NDEF text walk.
// Depends on ntre_pkg and the unit RTL only.
`timescale 1ns / 1ps

module tb_ndef_text_record_extractor_unit;
   import ntre_pkg::*;

   localparam int RANDOM_BYTES_PER_PHASE = 300;
   localparam int DRAIN_CYCLES           = 8;
   localparam logic [CSR_ADDR_W-1:0] WANTED_TYPE_ADDR =
      CSR_ADDR_W'(4 * int'(CSR_IDX_WANTED_TYPE));

   typedef enum logic [3:0] {
      P_TLV_TYPE, P_TLV_LEN, P_TLV_LEN_HI, P_TLV_LEN_LO, P_TLV_SKIP,
      P_REC_FLAGS, P_REC_TLEN, P_REC_PLEN, P_REC_IDLEN, P_REC_TYPE, P_REC_SKIP,
      P_TXT_ID, P_TXT_STATUS, P_TXT_LANG, P_TXT_BODY, P_DONE
   } walk_phase_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   rsp_payload_type       rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ndef_text_record_extractor_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model state
   logic [7:0]      wanted_type_reg;
   walk_phase_type  walk_phase;
   logic [15:0]     tlv_left;
   logic [7:0]      rec_flags;
   logic [7:0]      type_len;
   logic [7:0]      id_len;
   logic [31:0]     payload_left;
   logic [1:0]      len_idx;
   logic [7:0]      lang_left;
   logic [32:0]     skip_left;
   logic            search_done;
   logic            tlv_is_ndef;
   logic            res_pending;
   rsp_payload_type pending_result;

   rsp_payload_type expected_results[$];
   logic [7:0]      tag_bytes[$];
   logic [7:0]      ndef_msg[$];
   int              error_count = 0;
   int              bytes_sent = 0;
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;

   function automatic void clear_walk();
      walk_phase   = P_TLV_TYPE;
      tlv_left     = '0;
      rec_flags    = '0;
      type_len     = '0;
      id_len       = '0;
      payload_left = '0;
      len_idx      = '0;
      lang_left    = '0;
      skip_left    = '0;
      search_done  = 1'b0;
      tlv_is_ndef  = 1'b0;
   endfunction

   function automatic void post_result(input logic [7:0] ch, input logic has,
                                       input logic [2:0] outcome, input logic last);
      res_pending                 = 1'b1;
      pending_result.text_byte    = has ? ch : 8'd0;
      pending_result.has_byte     = has;
      pending_result.outcome      = outcome;
      pending_result.last         = last;
   endfunction

   function automatic void finish_search(input logic [2:0] outcome);
      post_result(8'd0, 1'b0, outcome, 1'b1);
      search_done = 1'b1;
      walk_phase  = P_DONE;
   endfunction

   function automatic void record_end();
      if (tlv_left == 0)
         walk_phase = P_TLV_TYPE;
      else if (rec_flags[FLAG_ME_BIT])
         walk_phase = P_TLV_SKIP;
      else
         walk_phase = P_REC_FLAGS;
   endfunction

   function automatic void start_skip(input logic [32:0] n);
      skip_left = n;
      if (n == 0)
         record_end();
      else
         walk_phase = P_REC_SKIP;
   endfunction

   function automatic void header_done();
      if (rec_flags[2:0] == TNF_WELL_KNOWN && type_len == 8'd1)
         walk_phase = P_REC_TYPE;
      else
         start_skip(33'(type_len) + 33'(id_len) + 33'(payload_left));
   endfunction

   function automatic void begin_text();
      if (payload_left == 0)
         finish_search(OUTCOME_COMPLETE);
      else
         walk_phase = P_TXT_STATUS;
   endfunction

   function automatic void text_or_complete();
      if (payload_left == 0)
         finish_search(OUTCOME_COMPLETE);
      else
         walk_phase = P_TXT_BODY;
   endfunction

   function automatic void tlv_length_known(input logic [15:0] len);
      tlv_left = len;
      if (len == 0)
         walk_phase = P_TLV_TYPE;
      else
         walk_phase = tlv_is_ndef ? P_REC_FLAGS : P_TLV_SKIP;
   endfunction

   // Advance the walk by one tag byte; returns 1 when the byte yields a result.
   function automatic logic predict_text_result(input logic [7:0] b, input logic eoc,
                                                output rsp_payload_type res);
      logic        was_done;
      logic        len_done;
      logic [31:0] lang;
      res_pending    = 1'b0;
      pending_result = '0;
      was_done       = search_done;
      if (!was_done) begin
         if (walk_phase >= P_REC_FLAGS && walk_phase <= P_TXT_BODY && tlv_left != 0)
            tlv_left--;
         case (walk_phase)
            P_TLV_TYPE: begin
               if (b == TLV_TERM) begin
                  finish_search(OUTCOME_TERM_TLV);
               end else if (b != TLV_NULL) begin
                  tlv_is_ndef = (b == TLV_NDEF);
                  walk_phase  = P_TLV_LEN;
               end
            end
            P_TLV_LEN: begin
               if (b == TLV_LEN_LONG)
                  walk_phase = P_TLV_LEN_HI;
               else
                  tlv_length_known(16'(b));
            end
            P_TLV_LEN_HI: begin
               tlv_left   = {b, 8'd0};
               walk_phase = P_TLV_LEN_LO;
            end
            P_TLV_LEN_LO: tlv_length_known(tlv_left | 16'(b));
            P_TLV_SKIP: begin
               if (tlv_left != 0) tlv_left--;
               if (tlv_left == 0) walk_phase = P_TLV_TYPE;
            end
            P_REC_FLAGS: begin
               rec_flags    = b;
               type_len     = '0;
               id_len       = '0;
               payload_left = '0;
               len_idx      = '0;
               walk_phase   = P_REC_TLEN;
            end
            P_REC_TLEN: begin
               type_len   = b;
               walk_phase = P_REC_PLEN;
            end
            P_REC_PLEN: begin
               if (rec_flags[FLAG_SR_BIT]) begin
                  payload_left = 32'(b);
                  len_done     = 1'b1;
               end else begin
                  payload_left = {payload_left[23:0], b};
                  len_done     = (len_idx == 2'd3);
                  len_idx++;
               end
               if (len_done) begin
                  if (rec_flags[FLAG_IL_BIT])
                     walk_phase = P_REC_IDLEN;
                  else
                     header_done();
               end
            end
            P_REC_IDLEN: begin
               id_len = b;
               header_done();
            end
            P_REC_TYPE: begin
               if (b == wanted_type_reg) begin
                  skip_left = 33'(id_len);
                  if (id_len == 0)
                     begin_text();
                  else
                     walk_phase = P_TXT_ID;
               end else begin
                  start_skip(33'(id_len) + 33'(payload_left));
               end
            end
            P_REC_SKIP: begin
               if (skip_left != 0) skip_left--;
               if (skip_left == 0) record_end();
            end
            P_TXT_ID: begin
               if (skip_left != 0) skip_left--;
               if (skip_left == 0) begin_text();
            end
            P_TXT_STATUS: begin
               // only the low six status bits give the language length
               lang = 32'(b[5:0]);
               if (payload_left != 0) payload_left--;
               if (lang > payload_left) lang = payload_left;
               lang_left    = lang[7:0];
               payload_left = payload_left - lang;
               if (lang_left != 0)
                  walk_phase = P_TXT_LANG;
               else
                  text_or_complete();
            end
            P_TXT_LANG: begin
               if (lang_left != 0) lang_left--;
               if (lang_left == 0) text_or_complete();
            end
            P_TXT_BODY: begin
               if (payload_left != 0) payload_left--;
               if (payload_left == 0) begin
                  post_result(b, 1'b1, OUTCOME_COMPLETE, 1'b1);
                  search_done = 1'b1;
                  walk_phase  = P_DONE;
               end else begin
                  post_result(b, 1'b1, OUTCOME_CONTINUE, 1'b0);
               end
            end
            default: ;
         endcase
      end
      if (eoc && !was_done) begin
         if (res_pending) begin
            if (!pending_result.last) begin
               pending_result.outcome = OUTCOME_TRUNCATED;
               pending_result.last    = 1'b1;
            end
         end else if (walk_phase >= P_TXT_ID && walk_phase <= P_TXT_BODY) begin
            post_result(8'd0, 1'b0, OUTCOME_TRUNCATED, 1'b1);
         end else begin
            post_result(8'd0, 1'b0, OUTCOME_NO_TEXT, 1'b1);
         end
      end
      if (eoc) clear_walk();
      res = pending_result;
      return res_pending;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_tag_byte(input logic [7:0] value, input logic eoc);
      rsp_payload_type res;
      @(negedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: value, end_of_content: eoc};
      do @(posedge clock); while (!req_ready);
      if (predict_text_result(value, eoc, res))
         expected_results.push_back(res);
      bytes_sent++;
   endtask

   task automatic send_tag();
      foreach (tag_bytes[i])
         send_tag_byte(tag_bytes[i], i == tag_bytes.size() - 1);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // a trailing byte may still be in flight without a result
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_wanted_type(input logic [7:0] value);
      logic [CSR_DATA_W-1:0] word;
      word      = CSR_DATA_W'($urandom);
      word[7:0] = value;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= WANTED_TYPE_ADDR;
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      wanted_type_reg = value;
      // read back through a second transfer
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[7:0] !== value) begin
         $display("%0t: wanted type readback mismatch: expected %02h actual %02h",
                  $time, value, prdata[7:0]);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %s",
                     $time, "beat below");
            $display("%0t:    actual byte=%02h has=%0b outcome=%0d last=%0b",
                     $time, rsp_payload.text_byte, rsp_payload.has_byte,
                     rsp_payload.outcome, rsp_payload.last);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.text_byte !== want.text_byte ||
                rsp_payload.has_byte !== want.has_byte ||
                rsp_payload.outcome !== want.outcome ||
                rsp_payload.last !== want.last) begin
               $display("%0t: result mismatch: expected byte=%02h has=%0b outcome=%0d last=%0b",
                        $time, want.text_byte, want.has_byte, want.outcome, want.last);
               $display("%0t:                  actual   byte=%02h has=%0b outcome=%0d last=%0b",
                        $time, rsp_payload.text_byte, rsp_payload.has_byte,
                        rsp_payload.outcome, rsp_payload.last);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic append_random_record(input logic is_last);
      logic       is_match;
      logic       short_len;
      logic       has_id;
      logic [2:0] tnf;
      logic [7:0] flags;
      logic [7:0] rec_type;
      logic [7:0] type_n;
      logic [7:0] id_n;
      logic [7:0] payload[$];
      is_match  = ($urandom_range(99) < 55);
      short_len = ($urandom_range(99) < 80);
      has_id    = ($urandom_range(3) == 0);
      id_n      = has_id ? 8'($urandom_range(0, 3)) : 8'd0;
      if (is_match) begin
         tnf      = TNF_WELL_KNOWN;
         type_n   = 8'd1;
         rec_type = wanted_type_reg;
         // mostly a status byte plus text, sometimes an empty payload
         if ($urandom_range(9) != 0) begin
            payload.push_back({2'($urandom), ($urandom_range(9) == 0) ?
                               6'($urandom) : 6'($urandom_range(0, 3))});
            repeat ($urandom_range(0, 15)) payload.push_back(8'($urandom));
         end
      end else begin
         if ($urandom_range(1)) begin
            tnf      = TNF_WELL_KNOWN;
            type_n   = 8'd1;
            rec_type = wanted_type_reg ^ 8'($urandom_range(1, 255));
         end else begin
            tnf      = 3'($urandom);
            type_n   = 8'($urandom_range(0, 3));
            rec_type = 8'($urandom);
         end
         repeat ($urandom_range(0, 10)) payload.push_back(8'($urandom));
      end
      flags              = 8'($urandom);
      flags[FLAG_ME_BIT] = is_last;
      flags[FLAG_SR_BIT] = short_len;
      flags[FLAG_IL_BIT] = has_id;
      flags[2:0]         = tnf;
      ndef_msg.push_back(flags);
      ndef_msg.push_back(type_n);
      if (short_len) begin
         ndef_msg.push_back(8'(payload.size()));
      end else if ($urandom_range(49) == 0) begin
         // oversized length that runs off the end of the tag
         repeat (4) ndef_msg.push_back(8'($urandom));
      end else begin
         repeat (3) ndef_msg.push_back(8'd0);
         ndef_msg.push_back(8'(payload.size()));
      end
      if (has_id) ndef_msg.push_back(id_n);
      if (type_n != 0) begin
         ndef_msg.push_back(rec_type);
         repeat (type_n - 1) ndef_msg.push_back(8'($urandom));
      end
      repeat (id_n) ndef_msg.push_back(8'($urandom));
      foreach (payload[i]) ndef_msg.push_back(payload[i]);
   endtask

   task automatic build_random_tag();
      int         n_rec;
      int         tlv_len;
      int         junk;
      int         pick;
      int         body_n;
      int         keep;
      logic [7:0] other_type;
      tag_bytes.delete();
      ndef_msg.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 20)) tag_bytes.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(0, 2)) tag_bytes.push_back(TLV_NULL);
         if ($urandom_range(3) == 0) begin
            do other_type = 8'($urandom);
            while (other_type inside {TLV_NULL, TLV_NDEF, TLV_TERM});
            body_n = $urandom_range(0, 5);
            tag_bytes.push_back(other_type);
            if ($urandom_range(1)) begin
               tag_bytes.push_back(TLV_LEN_LONG);
               tag_bytes.push_back(8'd0);
            end
            tag_bytes.push_back(8'(body_n));
            repeat (body_n) tag_bytes.push_back(8'($urandom));
         end
         n_rec = $urandom_range(1, 3);
         for (int i = 0; i < n_rec; i++)
            append_random_record(i == n_rec - 1);
         tlv_len = ndef_msg.size();
         junk    = 0;
         pick    = $urandom_range(9);
         if (pick == 0) begin
            // message ends before the TLV does
            junk    = $urandom_range(1, 4);
            tlv_len = tlv_len + junk;
         end else if (pick == 1 && tlv_len > 1) begin
            // last record overruns its TLV
            tlv_len = tlv_len - 1;
         end
         tag_bytes.push_back(TLV_NDEF);
         if (tlv_len > 254 || $urandom_range(4) == 0) begin
            tag_bytes.push_back(TLV_LEN_LONG);
            tag_bytes.push_back(8'(tlv_len >> 8));
            tag_bytes.push_back(8'(tlv_len));
         end else begin
            tag_bytes.push_back(8'(tlv_len));
         end
         foreach (ndef_msg[i]) tag_bytes.push_back(ndef_msg[i]);
         repeat (junk) tag_bytes.push_back(8'($urandom));
         if ($urandom_range(1)) tag_bytes.push_back(TLV_TERM);
         repeat ($urandom_range(0, 2)) tag_bytes.push_back(8'($urandom));
         if ($urandom_range(6) == 0) begin
            keep = $urandom_range(1, tag_bytes.size());
            while (tag_bytes.size() > keep) void'(tag_bytes.pop_back());
         end
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_terminator_tlv();
      // null TLV, terminator, then a byte after the search that gives nothing
      tag_bytes = '{TLV_NULL, TLV_TERM, 8'h55};
      send_tag();
   endtask

   task automatic test_empty_text();
      // one-byte payload: status claims 63 language bytes, cut to none
      tag_bytes = '{TLV_NDEF, 8'h05, 8'hD1, 8'h01, 8'h01, 8'h54, 8'h3F};
      send_tag();
   endtask

   task automatic test_long_tlv_skip();
      // foreign TLV with a three-byte length, then content ends with no text
      tag_bytes = '{8'h01, TLV_LEN_LONG, 8'h00, 8'h01, 8'hAA, TLV_NULL};
      send_tag();
   endtask

   task automatic test_truncated_text();
      // "en" text record, content ends on the first text character
      tag_bytes = '{TLV_NDEF, 8'h09, 8'hD1, 8'h01, 8'h05, 8'h54, 8'h02,
                    8'h65, 8'h6E, 8'h48};
      send_tag();
   endtask

   task automatic test_random_tags(input idle_mode_type mode, input logic [7:0] wanted);
      wait_for_idle();
      write_wanted_type(wanted);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct    = 67;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 67;
         end
         default: begin
            sender_idle_pct    = 19;
            receiver_stall_pct = 19;
         end
      endcase
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES_PER_PHASE) begin
         build_random_tag();
         send_tag();
      end
   endtask

   initial begin
      wanted_type_reg = WANTED_TYPE_RESET;
      clear_walk();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_terminator_tlv();
      test_empty_text();
      test_long_tlv_skip();
      test_truncated_text();
      test_random_tags(IDLE_NONE, 8'h00);
      test_random_tags(IDLE_SENDER, 8'hFF);
      test_random_tags(IDLE_RECEIVER, WANTED_TYPE_RESET);
      test_random_tags(IDLE_BOTH, 8'($urandom));
      test_random_tags(IDLE_NONE, 8'($urandom));
      wait_for_idle();
      if (error_count == 0)
         $display("[ndef_text_record_extractor_unit] OK");
      else
         $display("[ndef_text_record_extractor_unit] ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[ndef_text_record_extractor_unit] ERROR");
      $finish;
   end

endmodule
